[hw/rtl/dbtls_pkg.sv]
`default_nettype none

package dbtls_pkg;

  // one input request: a greeting byte and the end-of-buffer mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  // one result request
  typedef struct packed {
    logic packet_complete;
    logic tls_supported;
  } out_req_t;

  localparam int unsigned CountW = 25;
  localparam int unsigned LenW   = 24;
  localparam int unsigned AfterW = 5;

  localparam logic [CountW-1:0] COUNT_MAX     = '1;
  localparam logic [AfterW-1:0] AFTER_MAX     = '1;
  localparam logic [7:0]        PROTO_VERSION = 8'h0A;
  localparam logic [CountW-1:0] VERSION_POS   = CountW'(4);
  localparam logic [CountW-1:0] SEARCH_POS    = CountW'(5);
  localparam logic [CountW-1:0] LEN_BYTES     = CountW'(3);
  localparam logic [AfterW-1:0] CAP_LOW_POS   = AfterW'(14);
  localparam logic [AfterW-1:0] CAP_HIGH_POS  = AfterW'(15);
  // capability bit 11 is bit 3 of the high capability byte
  localparam int unsigned       SSL_HIGH_BIT  = 3;
  localparam logic [CountW:0]   HEADER_BYTES  = (CountW+1)'(4);

endpackage

`default_nettype wire

[hw/rtl/db_handshake_tls_flag_parser_top.sv]
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   dbtls_pkg::in_req_t  (data_byte, last_byte)
// out_     output     out_valid/out_stall dbtls_pkg::out_req_t (packet_complete, tls_supported)
//
// one byte is taken every cycle while in_stall is low; the parse state updates in the cycle it is taken
// a final byte's result goes to the output register, or to the skid register while out_ is stalled
// the output register plus one skid register keep input flowing under out_stall until the skid fills
// in_stall rises only when the skid register holds a result
// rst_n is synchronous and clears the parse state and the valid bits of both result registers
`default_nettype none

module db_handshake_tls_flag_parser_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dbtls_pkg::in_req_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dbtls_pkg::out_req_t      out_data
);

  logic                accept;
  logic                res_valid;
  dbtls_pkg::out_req_t res_data;

  logic                out_valid_r;
  dbtls_pkg::out_req_t out_data_r;
  logic                skid_valid_r;
  dbtls_pkg::out_req_t skid_data_r;
  logic                out_free;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  dbtls_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // output register with skid stage
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
        out_data_r  <= res_data;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // skid only ever holds a request behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output register is empty");

  // skid fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without an output stall");

  // tls support requires a complete packet
  a_tls_needs_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.tls_supported || out_data_r.packet_complete))
    else $error("tls reported on an incomplete packet");
`endif

endmodule

`default_nettype wire

[hw/rtl/dbtls_parser.sv]
`default_nettype none

module dbtls_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire dbtls_pkg::in_req_t in_data,
  output logic                    res_valid,
  output dbtls_pkg::out_req_t     res_data
);

  logic [dbtls_pkg::CountW-1:0] count_r, count_nxt;
  logic [dbtls_pkg::LenW-1:0]   len_r, len_nxt;
  logic                         ver_ok_r, ver_ok_nxt;
  logic                         nul_seen_r, nul_seen_nxt;
  logic [dbtls_pkg::AfterW-1:0] after_r, after_nxt;
  logic                         low_seen_r, low_seen_nxt;
  logic [7:0]                   high_byte_r, high_byte_nxt;
  logic                         high_seen_r, high_seen_nxt;

  logic [dbtls_pkg::CountW:0]   need;
  logic                         complete;
  logic [7:0]                   b;

  assign b = in_data.data_byte;

  // absorb one byte into the parse state
  always_comb begin
    count_nxt     = count_r;
    len_nxt       = len_r;
    ver_ok_nxt    = ver_ok_r;
    nul_seen_nxt  = nul_seen_r;
    after_nxt     = after_r;
    low_seen_nxt  = low_seen_r;
    high_byte_nxt = high_byte_r;
    high_seen_nxt = high_seen_r;

    // length bytes, little endian
    if (count_r < dbtls_pkg::LEN_BYTES) begin
      case (count_r[1:0])
        2'd0:    len_nxt[7:0]   = b;
        2'd1:    len_nxt[15:8]  = b;
        2'd2:    len_nxt[23:16] = b;
        default: len_nxt        = len_r;
      endcase
    end else if (count_r == dbtls_pkg::VERSION_POS) begin
      ver_ok_nxt = (b == dbtls_pkg::PROTO_VERSION);
    end

    // nul search, then capability capture
    if (nul_seen_r) begin
      if (after_r != dbtls_pkg::AFTER_MAX) begin
        after_nxt = after_r + dbtls_pkg::AfterW'(1);
      end
      if (after_nxt == dbtls_pkg::CAP_LOW_POS) begin
        low_seen_nxt = 1'b1;
      end else if (after_nxt == dbtls_pkg::CAP_HIGH_POS) begin
        high_byte_nxt = b;
        high_seen_nxt = 1'b1;
      end
    end else if (count_r >= dbtls_pkg::SEARCH_POS && b == 8'h00) begin
      nul_seen_nxt = 1'b1;
      after_nxt    = '0;
    end

    // saturating byte count
    if (count_r != dbtls_pkg::COUNT_MAX) begin
      count_nxt = count_r + dbtls_pkg::CountW'(1);
    end
  end

  // result from the state after this byte
  assign need      = dbtls_pkg::HEADER_BYTES + {1'b0, {(dbtls_pkg::CountW-dbtls_pkg::LenW){1'b0}},
                                                len_nxt};
  assign complete  = {1'b0, count_nxt} >= need;
  assign res_valid = accept && in_data.last_byte;

  always_comb begin
    res_data.packet_complete = complete;
    res_data.tls_supported   = complete && ver_ok_nxt && nul_seen_nxt && low_seen_nxt &&
                               high_seen_nxt && high_byte_nxt[dbtls_pkg::SSL_HIGH_BIT];
  end

  // state update; the final byte clears everything
  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      count_r     <= '0;
      len_r       <= '0;
      ver_ok_r    <= 1'b0;
      nul_seen_r  <= 1'b0;
      after_r     <= '0;
      low_seen_r  <= 1'b0;
      high_byte_r <= '0;
      high_seen_r <= 1'b0;
    end else if (accept) begin
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      ver_ok_r    <= ver_ok_nxt;
      nul_seen_r  <= nul_seen_nxt;
      after_r     <= after_nxt;
      low_seen_r  <= low_seen_nxt;
      high_byte_r <= high_byte_nxt;
      high_seen_r <= high_seen_nxt;
    end
  end

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  dbtls_pkg::in_req_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dbtls_pkg::out_req_t out_data;

  // greeting parser mirror
  logic [dbtls_pkg::CountW-1:0] seen_count;
  logic [dbtls_pkg::LenW-1:0]   length_field;
  logic                         version_match;
  logic                         nul_found;
  logic [dbtls_pkg::AfterW-1:0] after_nul;
  logic                         cap_low_got;
  logic                         cap_high_got;
  logic [7:0]                   cap_high;

  dbtls_pkg::out_req_t expected_verdicts[$];
  int       mismatches       = 0;
  int       verdicts_due     = 0;
  int       bytes_sent       = 0;
  int       send_idle_pct    = 0;
  int       recv_stall_pct   = 0;

  db_handshake_tls_flag_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic clear_parse_state();
    seen_count    = '0;
    length_field  = '0;
    version_match = 1'b0;
    nul_found     = 1'b0;
    after_nul     = '0;
    cap_low_got   = 1'b0;
    cap_high_got  = 1'b0;
    cap_high      = '0;
  endtask

  // track one accepted byte; on the final byte queue the expected verdict
  task automatic absorb_greeting_byte(input dbtls_pkg::in_req_t req);
    logic                complete;
    dbtls_pkg::out_req_t verdict;
    if (seen_count < dbtls_pkg::LEN_BYTES) begin
      case (seen_count[1:0])
        2'd0: length_field[7:0]   = req.data_byte;
        2'd1: length_field[15:8]  = req.data_byte;
        default: length_field[23:16] = req.data_byte;
      endcase
    end else if (seen_count == dbtls_pkg::VERSION_POS) begin
      version_match = (req.data_byte == dbtls_pkg::PROTO_VERSION);
    end

    // server version string ends at the first nul from byte 5 on
    if (nul_found) begin
      if (after_nul != dbtls_pkg::AFTER_MAX) after_nul = after_nul + dbtls_pkg::AfterW'(1);
      if (after_nul == dbtls_pkg::CAP_LOW_POS) begin
        cap_low_got = 1'b1;
      end else if (after_nul == dbtls_pkg::CAP_HIGH_POS) begin
        cap_high     = req.data_byte;
        cap_high_got = 1'b1;
      end
    end else if (seen_count >= dbtls_pkg::SEARCH_POS && req.data_byte == 8'h00) begin
      nul_found = 1'b1;
      after_nul = '0;
    end

    if (seen_count != dbtls_pkg::COUNT_MAX) seen_count = seen_count + dbtls_pkg::CountW'(1);

    if (req.last_byte) begin
      complete = ({1'b0, seen_count} >= dbtls_pkg::HEADER_BYTES + {2'b00, length_field});
      verdict.packet_complete = complete;
      verdict.tls_supported   = complete && version_match && nul_found && cap_low_got &&
                                cap_high_got && cap_high[dbtls_pkg::SSL_HIGH_BIT];
      expected_verdicts = {expected_verdicts, verdict};
      verdicts_due++;
      clear_parse_state();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected verdict: complete=%0b tls=%0b",
                   out_data.packet_complete, out_data.tls_supported);
      end else begin
        if (out_data.packet_complete !== expected_verdicts[0].packet_complete ||
            out_data.tls_supported !== expected_verdicts[0].tls_supported) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: expected complete=%0b tls=%0b, got complete=%0b tls=%0b",
                     expected_verdicts[0].packet_complete, expected_verdicts[0].tls_supported,
                     out_data.packet_complete, out_data.tls_supported);
        end
        void'(expected_verdicts.pop_front());
      end
    end
  end

  // one byte request, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] data, input logic last);
    dbtls_pkg::in_req_t req;
    req.data_byte = data;
    req.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    absorb_greeting_byte(req);
    bytes_sent++;
  endtask

  // first n bytes of a buffer, last mark on the final one
  task automatic send_buffer(input byte_q_t pkt, input int n);
    for (int i = 0; i < n; i++) send_byte(pkt[i], (i == n - 1));
  endtask

  // handshake greeting with random content and a length near the true size
  task automatic make_greeting(input bit good_version, input bit tls_on, output byte_q_t pkt);
    logic [7:0]  b;
    int          ver_len;
    int          tail_len;
    int          slack;
    logic [23:0] len;
    pkt = {};
    repeat (3) pkt = {pkt, 8'h00};
    pkt = {pkt, 8'($urandom_range(255))};
    if (good_version) begin
      b = dbtls_pkg::PROTO_VERSION;
    end else begin
      do b = 8'($urandom_range(255)); while (b == dbtls_pkg::PROTO_VERSION);
    end
    pkt = {pkt, b};
    ver_len = $urandom_range(10);
    repeat (ver_len) pkt = {pkt, 8'($urandom_range(1, 255))};
    pkt = {pkt, 8'h00};
    // thread id, salt and filler
    repeat (13) pkt = {pkt, 8'($urandom_range(255))};
    pkt = {pkt, 8'($urandom_range(255))};
    b = 8'($urandom_range(255));
    b[dbtls_pkg::SSL_HIGH_BIT] = tls_on;
    pkt = {pkt, b};
    tail_len = $urandom_range(24);
    repeat (tail_len) pkt = {pkt, 8'($urandom_range(255))};
    slack = $urandom_range(6) - 4;
    len = 24'(pkt.size() - 4 + slack);
    pkt[0] = len[7:0];
    pkt[1] = len[15:8];
    pkt[2] = len[23:16];
  endtask

  task automatic test_directed_cases();
    byte_q_t pkt;
    // lone byte with the largest length byte: incomplete
    pkt = '{8'hFF};
    send_buffer(pkt, 1);
    // header only with zero length: complete, no version byte
    pkt = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_buffer(pkt, 4);
    // shortest greeting that advertises tls, ending on the high capability byte
    pkt = '{8'd17, 8'h00, 8'h00, 8'h00, dbtls_pkg::PROTO_VERSION, 8'h00};
    repeat (13) pkt = {pkt, 8'hAA};
    pkt = {pkt, 8'h00};
    pkt = {pkt, 8'h08};
    send_buffer(pkt, pkt.size());
  endtask

  task automatic test_version_mismatch();
    byte_q_t pkt;
    repeat (4) begin
      make_greeting(1'b0, 1'b1, pkt);
      send_buffer(pkt, pkt.size());
    end
  endtask

  // well-formed greetings mostly, with truncated buffers and noise
  task automatic test_greeting_mix(input int idle_pct, input int stall_pct, input int n_bytes);
    byte_q_t pkt;
    int      kind;
    int      start_bytes;
    int      start_verdicts;
    int      n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_bytes    = bytes_sent;
    start_verdicts = verdicts_due;
    while (bytes_sent - start_bytes < n_bytes || verdicts_due - start_verdicts < 12) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        make_greeting(1'b1, $urandom_range(1), pkt);
        n = pkt.size();
      end else if (kind < 80) begin
        make_greeting(1'b0, $urandom_range(1), pkt);
        n = pkt.size();
      end else if (kind < 90) begin
        make_greeting(1'b1, 1'b1, pkt);
        n = $urandom_range(1, pkt.size());
      end else begin
        pkt = {};
        n = $urandom_range(1, 30);
        repeat (n) pkt = {pkt, 8'($urandom_range(255))};
      end
      send_buffer(pkt, n);
    end
  endtask

  // watchdog
  initial begin
    #5_000_000;
    $display("[db_handshake_tls_flag_parser_top] ERROR");
    $finish;
  end

  initial begin
    clear_parse_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_version_mismatch();
    test_greeting_mix(0, 0, 370);
    test_greeting_mix(61, 0, 370);
    test_greeting_mix(0, 61, 370);
    test_greeting_mix(7, 7, 370);

    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("[db_handshake_tls_flag_parser_top] OK");
    end else begin
      $display("[db_handshake_tls_flag_parser_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
